>>> src/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants, codes and types of the colour sensor classifier.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int CSC_COUNT_BITS = 16;

    // Fixed field widths
    localparam int MS_W     = 16;
    localparam int WEIGHT_W = 8;
    localparam int SCALE_W  = 8;   // width of the full-scale constant
    localparam int PCT_W    = 7;   // width of the percent divisor

    localparam logic [SCALE_W-1:0] SCALE_FULL = 8'd255;
    localparam logic [PCT_W-1:0]   PCT_DIV    = 7'd100;

    // Register reset values
    localparam logic [MS_W-1:0]     GATE_RESET   = 16'd500;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd85;

    // Register indexes (paddr[2])
    localparam logic REG_GATE   = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    // Commands
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_CAL    = 2'd1;
    localparam logic [1:0] MODE_MEAS   = 2'd2;

    // Run phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RED   = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;
    localparam logic [1:0] PH_GREEN = 2'd3;

    // Filter select codes
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_BLUE  = 2'd1;
    localparam logic [1:0] SEL_CLEAR = 2'd2;
    localparam logic [1:0] SEL_GREEN = 2'd3;

    // Colour codes
    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    // Measurement slots
    localparam logic [1:0] SLOT_RED   = 2'd0;
    localparam logic [1:0] SLOT_BLUE  = 2'd1;
    localparam logic [1:0] SLOT_GREEN = 2'd2;

    typedef struct packed {
        logic       done;
        logic [1:0] color;
    } csc_score_res_t;

    typedef struct packed {
        logic [1:0] color;
        logic       status;
        logic       done_res;
        logic       busy_res;
        logic       sensor_on;
        logic [1:0] channel_select;
    } csc_result_t;

    function automatic logic [1:0] sel_of_phase(input logic [1:0] ph);
        logic [1:0] sel;
        unique case (ph)
            PH_RED:   sel = SEL_RED;
            PH_BLUE:  sel = SEL_BLUE;
            PH_GREEN: sel = SEL_GREEN;
            default:  sel = SEL_RED;
        endcase
        return sel;
    endfunction

endpackage

>>> src/csc_serial_div.sv
// ----------------------------------------------------------------------------
// csc_serial_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csc_serial_div
    import csc_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 23
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(NUM_W);
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            // shift in the next dividend bit, keep the partial remainder below den
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

>>> src/csc_scorer.sv
// ----------------------------------------------------------------------------
// csc_scorer
// White-balanced scores of the three channels and pick of the largest.
// ----------------------------------------------------------------------------
module csc_scorer
    import csc_pkg::*;
#(
    parameter int COUNT_BITS = CSC_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] meas [0:2],
    input  logic [COUNT_BITS-1:0] refc [0:2],
    input  logic [WEIGHT_W-1:0]   weight,
    output csc_score_res_t        res
);

    localparam int M_W   = COUNT_BITS + SCALE_W;
    localparam int NUM_W = M_W + WEIGHT_W;
    localparam int DEN_W = COUNT_BITS + PCT_W;

    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_LOAD = 2'd1;
    localparam logic [1:0] SC_DIV  = 2'd2;
    localparam logic [1:0] SC_PICK = 2'd3;

    logic [1:0]       st_reg, st_next;
    logic [1:0]       ch_reg, ch_next;
    logic [NUM_W-1:0] q_reg [0:2];

    logic [M_W-1:0]      m255;
    logic [WEIGHT_W-1:0] w_sel;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    den;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;

    // red carries the percent weight over a hundredfold reference
    assign m255  = M_W'(meas[ch_reg]) * M_W'(SCALE_FULL);
    assign w_sel = (ch_reg == SLOT_RED) ? weight : WEIGHT_W'(1);
    assign num   = NUM_W'(m255) * NUM_W'(w_sel);
    assign den   = (ch_reg == SLOT_RED) ? DEN_W'(refc[ch_reg]) * DEN_W'(PCT_DIV)
                                        : DEN_W'(refc[ch_reg]);
    assign div_start = (st_reg == SC_LOAD);

    csc_serial_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        st_next = st_reg;
        ch_next = ch_reg;
        unique case (st_reg)
            SC_IDLE: begin
                if (start) begin
                    st_next = SC_LOAD;
                    ch_next = SLOT_RED;
                end
            end
            SC_LOAD: st_next = SC_DIV;
            SC_DIV: begin
                if (div_done) begin
                    if (ch_reg == SLOT_GREEN) begin
                        st_next = SC_PICK;
                    end else begin
                        st_next = SC_LOAD;
                        ch_next = ch_reg + 2'd1;
                    end
                end
            end
            SC_PICK: st_next = SC_IDLE;
            default: st_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= SC_IDLE;
            ch_reg <= SLOT_RED;
        end else begin
            st_reg <= st_next;
            ch_reg <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == SC_DIV && div_done) begin
            q_reg[ch_reg] <= div_quo;
        end
    end

    // ties go to red, then green
    always_comb begin
        res.done = (st_reg == SC_PICK);
        if (q_reg[SLOT_RED] >= q_reg[SLOT_GREEN] && q_reg[SLOT_RED] >= q_reg[SLOT_BLUE]) begin
            res.color = COLOR_RED;
        end else if (q_reg[SLOT_GREEN] >= q_reg[SLOT_BLUE]) begin
            res.color = COLOR_GREEN;
        end else begin
            res.color = COLOR_BLUE;
        end
    end

endmodule

>>> src/color_sensor_classifier_unit.sv
// ----------------------------------------------------------------------------
// color_sensor_classifier_unit
// Colour sensor sequencer with white balance and dominant colour pick.
// ----------------------------------------------------------------------------
// Each input beat is one sample period (command, sensor edge, millisecond
// tick) and produces exactly one result beat. A calibration or measure command
// starts a run that selects the red, blue and green filters in turn, counting
// sensor edges (saturating at all ones of COUNT_BITS bits) for gate_ms ticks
// per channel. A calibration run keeps the counts as white references; a
// measure run scores each channel against its reference and reports the
// largest, ties going to red, then green. An ordinary sample's result is
// registered and ready in the next cycle; the input accepts again as soon as
// the output register is empty or being emptied. The result of the sample
// that ends a measure run appears once the bit-serial divider has worked out
// the three scores one quotient bit per cycle. gate_ms (address 0) and
// red_weight_pct (address 4) are written over the APB port; the user must write
// them only while no run or result is pending; the block does not enforce it.
// ----------------------------------------------------------------------------
module color_sensor_classifier_unit
    import csc_pkg::*;
#(
    parameter int COUNT_BITS = CSC_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] mode, [2] rise, [3] ms_tick, [7:4] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] channel_select, [2] sensor_on, [3] busy_res,
                                   // [4] done_res, [5] status, [7:6] color
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SCORE = 1'b1;

    // Configuration registers
    logic [MS_W-1:0]     gate_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                cfg_wr;
    logic                cfg_idx;

    // Run state
    logic [1:0]            phase_reg, phase_next;
    logic                  run_cal_reg, run_cal_next;
    logic [COUNT_BITS-1:0] edge_cnt_reg, edge_cnt_next, edge_inc;
    logic [MS_W-1:0]       ms_cnt_reg, ms_cnt_next;
    logic [COUNT_BITS-1:0] meas_reg [0:2];
    logic [COUNT_BITS-1:0] ref_reg  [0:2];
    logic                  calibrated_reg, calibrated_next;
    logic [1:0]            last_color_reg;

    logic       st_reg;
    logic       m_valid_reg;
    csc_result_t out_reg;
    csc_result_t item_res;

    logic       s_fire;
    logic [1:0] mode;
    logic       rise;
    logic       ms_tick;
    logic [MS_W:0] ms_inc;
    logic       gate_hit;
    logic       meas_wr;
    logic [1:0] meas_slot;
    logic       ref_wr;
    logic       score_start;
    csc_score_res_t score_res;

    // ------------------------------------------------------------------
    // APB: always ready, write on the access cycle
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg   <= GATE_RESET;
            weight_reg <= WEIGHT_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx == REG_GATE) begin
                gate_reg <= pwdata[MS_W-1:0];
            end else begin
                weight_reg <= pwdata[WEIGHT_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GATE:   prdata = {{(32-MS_W){1'b0}}, gate_reg};
            REG_WEIGHT: prdata = {{(32-WEIGHT_W){1'b0}}, weight_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input beat decode
    // ------------------------------------------------------------------
    assign s_tready = (st_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign mode     = s_tdata[1:0];
    assign rise     = s_tdata[2];
    assign ms_tick  = s_tdata[3];

    // saturate the edge count, close the gate on the last tick
    assign edge_inc = (rise && !(&edge_cnt_reg)) ? edge_cnt_reg + COUNT_BITS'(1)
                                                  : edge_cnt_reg;
    assign ms_inc   = {1'b0, ms_cnt_reg} + (MS_W+1)'(1);
    assign gate_hit = ms_inc >= {1'b0, gate_reg};

    // ------------------------------------------------------------------
    // Per-sample sequencing
    // ------------------------------------------------------------------
    always_comb begin
        phase_next      = phase_reg;
        run_cal_next    = run_cal_reg;
        edge_cnt_next   = edge_cnt_reg;
        ms_cnt_next     = ms_cnt_reg;
        calibrated_next = calibrated_reg;
        meas_wr         = 1'b0;
        meas_slot       = phase_reg - 2'd1;
        ref_wr          = 1'b0;
        score_start     = 1'b0;
        item_res        = '0;
        item_res.color  = last_color_reg;

        if (phase_reg == PH_IDLE) begin
            if (mode == MODE_CAL || (mode == MODE_MEAS && calibrated_reg)) begin
                phase_next              = PH_RED;
                run_cal_next            = (mode == MODE_CAL);
                edge_cnt_next           = '0;
                ms_cnt_next             = '0;
                item_res.channel_select = sel_of_phase(PH_RED);
                item_res.sensor_on      = 1'b1;
                item_res.busy_res       = 1'b1;
            end else if (mode == MODE_MEAS) begin
                // refuse: no white balance yet
                item_res.sensor_on = 1'b1;
                item_res.done_res  = 1'b1;
                item_res.status    = 1'b1;
            end
        end else begin
            item_res.channel_select = sel_of_phase(phase_reg);
            item_res.sensor_on      = 1'b1;
            item_res.busy_res       = 1'b1;
            edge_cnt_next           = edge_inc;
            if (ms_tick) begin
                if (gate_hit) begin
                    meas_wr       = 1'b1;
                    edge_cnt_next = '0;
                    ms_cnt_next   = '0;
                    if (phase_reg == PH_GREEN) begin
                        phase_next        = PH_IDLE;
                        item_res.busy_res = 1'b0;
                        item_res.done_res = 1'b1;
                        if (run_cal_reg) begin
                            ref_wr          = 1'b1;
                            calibrated_next = 1'b1;
                        end else begin
                            score_start = 1'b1;
                        end
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end else begin
                    ms_cnt_next = ms_inc[MS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            run_cal_reg    <= 1'b0;
            edge_cnt_reg   <= '0;
            ms_cnt_reg     <= '0;
            calibrated_reg <= 1'b0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            run_cal_reg    <= run_cal_next;
            edge_cnt_reg   <= edge_cnt_next;
            ms_cnt_reg     <= ms_cnt_next;
            calibrated_reg <= calibrated_next;
        end
    end

    // Channel counts and white references; a zero reference is kept as one
    always_ff @(posedge aclk) begin
        if (s_fire && meas_wr) begin
            meas_reg[meas_slot] <= edge_inc;
        end
        if (s_fire && ref_wr) begin
            for (int i = 0; i < 3; i++) begin
                if (i == 2) begin
                    ref_reg[i] <= (edge_inc == '0) ? COUNT_BITS'(1) : edge_inc;
                end else begin
                    ref_reg[i] <= (meas_reg[i] == '0) ? COUNT_BITS'(1) : meas_reg[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoring at the end of a measure run
    // ------------------------------------------------------------------
    csc_scorer #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scorer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire && score_start),
        .meas    (meas_reg),
        .refc    (ref_reg),
        .weight  (weight_reg),
        .res     (score_res)
    );

    // ------------------------------------------------------------------
    // Control and output register: hold the result until its beat is taken
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            last_color_reg <= COLOR_RED;
        end else begin
            if (s_fire && score_start) begin
                st_reg      <= ST_SCORE;
                m_valid_reg <= 1'b0;
            end else if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (score_res.done) begin
                st_reg         <= ST_IDLE;
                m_valid_reg    <= 1'b1;
                last_color_reg <= score_res.color;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_reg <= item_res;
        end else if (score_res.done) begin
            out_reg.color <= score_res.color;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_score_only_when_waiting: assert property (
        @(posedge aclk) disable iff (!aresetn)
        score_res.done |-> st_reg == ST_SCORE
    ) else $error("score finished while not waiting for it");

    a_result_has_source: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_fire) || $past(score_res.done)
    ) else $error("result beat appeared without a sample or a score");

    a_measure_needs_balance: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE && !run_cal_reg) |-> calibrated_reg
    ) else $error("measure run active without white balance");

    a_scoring_between_runs: assert property (
        @(posedge aclk) disable iff (!aresetn)
        st_reg == ST_SCORE |-> phase_reg == PH_IDLE && !m_valid_reg
    ) else $error("scoring overlaps a run or a pending result");

endmodule
